// ===== rtl/ebpa_pkg.sv =====
// package for the extent bitmap page allocator
// holds request and status codes, the control state type, the memory command
// struct and a small helper function; no dependencies
package ebpa_pkg;

    // fixed field widths
    localparam int PAGE_W      = 12;
    localparam int PHYS_W      = 13;
    localparam int COUNT_W     = 13;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int ADDR_PAGES  = 4096;
    localparam int RECIP_SHIFT = 24;

    // request kinds; the unused code is served as a query
    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_READ,
        S_MOD,
        S_PHYS,
        S_DONE
    } state_t;

    // bitmap memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    // index of the lowest clear bit of a bitmap word
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/ebpa_bitmap_ram.sv =====
// used-page bitmap memory: one 64-bit word per entry, one read or write per cycle
// read data registered; per-word valid flops make unwritten words read as zero
// depends on ebpa_pkg
module ebpa_bitmap_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ebpa_pkg::mem_cmd_t                  cmd,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic [ebpa_pkg::WORD_BITS-1:0]      wdata,
    output logic [ebpa_pkg::WORD_BITS-1:0]      rdata
);

    logic [ebpa_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]               valid_reg;
    logic [ebpa_pkg::WORD_BITS-1:0] rdata_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read, cleared words read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    // word valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ebpa_phys_calc.sv =====
// physical position unit: page + page / PAGES_PER_EXTENT + 2, three stages
// the extent number comes from a reciprocal multiply with one correction step
// depends on ebpa_pkg
module ebpa_phys_calc #(
    parameter int PAGES_PER_EXTENT = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ebpa_pkg::PAGE_W-1:0]       page,
    output logic                              done,
    output logic [ebpa_pkg::PHYS_W-1:0]       phys
);

    localparam int RECIP   = (1 << ebpa_pkg::RECIP_SHIFT) / PAGES_PER_EXTENT;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PPE_W   = $clog2(PAGES_PER_EXTENT + 1);
    localparam int EXT_MAX = (ebpa_pkg::ADDR_PAGES - 1) / PAGES_PER_EXTENT;
    localparam int EXT_W   = (EXT_MAX > 0) ? $clog2(EXT_MAX + 1) : 1;
    localparam int PROD_W  = ebpa_pkg::PAGE_W + RECIP_W;

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          done_reg;
    logic [PROD_W-1:0]             prod1_reg;
    logic [ebpa_pkg::PAGE_W-1:0]   page1_reg;
    logic [ebpa_pkg::PAGE_W-1:0]   page2_reg;
    logic [EXT_W-1:0]              ext2_reg;
    logic [EXT_W+PPE_W-1:0]        prod2_reg;
    logic [ebpa_pkg::PHYS_W-1:0]   phys_reg;
    logic [EXT_W-1:0]              ext_est;
    logic [ebpa_pkg::PHYS_W-1:0]   rem;
    logic [EXT_W-1:0]              ext_fix;

    // extent estimate, low by at most one
    assign ext_est = prod1_reg[ebpa_pkg::RECIP_SHIFT +: EXT_W];

    // correction: remainder at or above extent size bumps the extent
    always_comb
    begin
        rem = ebpa_pkg::PHYS_W'(page2_reg) - ebpa_pkg::PHYS_W'(prod2_reg);
        if (rem >= ebpa_pkg::PHYS_W'(PAGES_PER_EXTENT))
        begin
            ext_fix = EXT_W'(ext2_reg + 1'b1);
        end
        else
        begin
            ext_fix = ext2_reg;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod1_reg <= PROD_W'(page) * PROD_W'(RECIP);
            page1_reg <= page;
        end
        if (v1_reg)
        begin
            ext2_reg  <= ext_est;
            prod2_reg <= (EXT_W + PPE_W)'(ext_est) * (EXT_W + PPE_W)'(PAGES_PER_EXTENT);
            page2_reg <= page1_reg;
        end
        if (v2_reg)
        begin
            phys_reg <= ebpa_pkg::PHYS_W'(page2_reg) + ebpa_pkg::PHYS_W'(ext_fix)
                        + ebpa_pkg::PHYS_W'(2);
        end
    end

    assign done = done_reg;
    assign phys = phys_reg;

endmodule

// ===== rtl/extent_bitmap_page_allocator.sv =====
// Extent bitmap page allocator. One request (allocate, free or query) is taken
// at a time and answered with one result word, in these steps: pick the bitmap
// word (for allocate, the first word with a clear bit, from per-word full
// flags), read the bitmap memory, test or pick the bit, run the physical
// position unit, and write the word back and load the output register. That
// last step waits while the previous result still sits unaccepted in the output
// register. A new request is accepted as soon as the previous result is loaded,
// even while that result still waits for the receiver. An allocation that is
// not refused returns the lowest free page, which is the lowest free page of
// the first extent that is not full. The bitmap and counters are clear right
// after reset; there is no clearing pass.
// depends on ebpa_pkg, ebpa_bitmap_ram, ebpa_phys_calc
module extent_bitmap_page_allocator #(
    parameter int PAGES_PER_EXTENT = 256,
    parameter int EXTENT_COUNT     = 16,
    parameter int PAGE_LIMIT       = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        kind,
    input  logic [ebpa_pkg::PAGE_W-1:0]       page_number,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [1:0]                        status,
    output logic [ebpa_pkg::PAGE_W-1:0]       result_page,
    output logic [ebpa_pkg::PHYS_W-1:0]       physical_page,
    output logic                              page_free
);

    localparam int TOTAL_PAGES = PAGES_PER_EXTENT * EXTENT_COUNT;
    localparam int LIVE_PAGES  = (TOTAL_PAGES < ebpa_pkg::ADDR_PAGES)
                                 ? TOTAL_PAGES : ebpa_pkg::ADDR_PAGES;
    localparam int NW          = (LIVE_PAGES + ebpa_pkg::WORD_BITS - 1) / ebpa_pkg::WORD_BITS;
    localparam int WW          = (NW > 1) ? $clog2(NW) : 1;
    localparam int TAIL_BITS   = LIVE_PAGES - (NW - 1) * ebpa_pkg::WORD_BITS;
    localparam logic [ebpa_pkg::WORD_BITS-1:0] TAIL_MASK =
        {ebpa_pkg::WORD_BITS{1'b1}} << TAIL_BITS;
    localparam int LIM_W       = $clog2(PAGE_LIMIT + 1);
    localparam int CMP_W       = (LIM_W > ebpa_pkg::COUNT_W) ? LIM_W : ebpa_pkg::COUNT_W;

    ebpa_pkg::state_t                  state_reg;
    ebpa_pkg::state_t                  state_next;
    ebpa_pkg::mem_cmd_t                mem_cmd;
    logic [ebpa_pkg::WORD_BITS-1:0]    mem_rdata;

    logic [1:0]                        kind_reg;
    logic [ebpa_pkg::PAGE_W-1:0]       pn_reg;
    logic [WW-1:0]                     word_idx_reg;
    logic                              fail_reg;
    logic [1:0]                        status_reg;
    logic [ebpa_pkg::PAGE_W-1:0]       page_reg;
    logic                              page_free_reg;
    logic [ebpa_pkg::WORD_BITS-1:0]    new_word_reg;
    logic                              new_full_reg;
    logic                              wr_reg;
    logic [ebpa_pkg::COUNT_W-1:0]      total_reg;
    logic [NW-1:0]                     full_reg;

    logic                              rsp_valid_reg;
    logic [1:0]                        status_out_reg;
    logic [ebpa_pkg::PAGE_W-1:0]       page_out_reg;
    logic [ebpa_pkg::PHYS_W-1:0]       phys_out_reg;
    logic                              free_out_reg;

    logic                              accept;
    logic                              load_out;
    logic                              phys_start;
    logic                              phys_done;
    logic [ebpa_pkg::PHYS_W-1:0]       phys_val;

    logic                              word_found;
    logic [WW-1:0]                     word_first;
    logic                              limit_hit;
    logic                              out_of_range;
    logic [ebpa_pkg::BIT_W-1:0]        pn_word6;
    logic [WW-1:0]                     find_idx;
    logic                              find_fail;
    logic [1:0]                        find_status;

    logic [ebpa_pkg::WORD_BITS-1:0]    tail_mask;
    logic [ebpa_pkg::WORD_BITS-1:0]    bit_mask;
    logic [ebpa_pkg::BIT_W-1:0]        alloc_bit;
    logic [ebpa_pkg::PAGE_W-1:0]       idx_ext;
    logic                              bit_used;
    logic [1:0]                        mod_status;
    logic [ebpa_pkg::PAGE_W-1:0]       mod_page;
    logic                              mod_free;
    logic [ebpa_pkg::WORD_BITS-1:0]    mod_word;
    logic                              mod_wr;

    // bitmap memory
    ebpa_bitmap_ram #(
        .DEPTH  (NW),
        .ADDR_W (WW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (word_idx_reg),
        .wdata (new_word_reg),
        .rdata (mem_rdata)
    );

    // physical position unit
    ebpa_phys_calc #(
        .PAGES_PER_EXTENT (PAGES_PER_EXTENT)
    ) u_phys (
        .clk   (clk),
        .rst_n (rst_n),
        .start (phys_start),
        .page  (mod_page),
        .done  (phys_done),
        .phys  (phys_val)
    );

    // first bitmap word that still has a free page
    always_comb
    begin
        word_found = 1'b0;
        word_first = '0;
        for (int i = NW - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                word_found = 1'b1;
                word_first = WW'(i);
            end
        end
    end

    // word selection and early refusals
    always_comb
    begin
        limit_hit    = (CMP_W'(total_reg) >= CMP_W'(PAGE_LIMIT));
        out_of_range = ({1'b0, pn_reg} >= (ebpa_pkg::PAGE_W + 1)'(LIVE_PAGES));
        pn_word6     = pn_reg[ebpa_pkg::PAGE_W-1:ebpa_pkg::BIT_W];
        if (kind_reg == ebpa_pkg::KIND_ALLOC)
        begin
            find_idx    = word_first;
            find_fail   = limit_hit || !word_found;
            find_status = ebpa_pkg::ST_NO_FREE;
        end
        else
        begin
            find_idx    = pn_word6[WW-1:0];
            find_fail   = out_of_range;
            find_status = ebpa_pkg::ST_OUT_OF_RANGE;
        end
    end

    // bit test, bit pick and word update
    always_comb
    begin
        tail_mask  = (word_idx_reg == WW'(NW - 1)) ? TAIL_MASK : '0;
        alloc_bit  = ebpa_pkg::first_zero(mem_rdata | tail_mask);
        idx_ext    = ebpa_pkg::PAGE_W'(word_idx_reg);
        bit_mask   = '0;
        bit_used   = mem_rdata[pn_reg[ebpa_pkg::BIT_W-1:0]];
        mod_status = ebpa_pkg::ST_OK;
        mod_page   = pn_reg;
        mod_free   = 1'b0;
        mod_word   = mem_rdata;
        mod_wr     = 1'b0;
        if (fail_reg)
        begin
            mod_status = status_reg;
            if (kind_reg == ebpa_pkg::KIND_ALLOC)
            begin
                mod_page = '0;
            end
        end
        else
        begin
            case (kind_reg)
                ebpa_pkg::KIND_ALLOC:
                begin
                    bit_mask[alloc_bit] = 1'b1;
                    mod_page = {idx_ext[ebpa_pkg::BIT_W-1:0], alloc_bit};
                    mod_word = mem_rdata | bit_mask;
                    mod_wr   = 1'b1;
                end
                ebpa_pkg::KIND_FREE:
                begin
                    bit_mask[pn_reg[ebpa_pkg::BIT_W-1:0]] = 1'b1;
                    mod_free = 1'b1;
                    if (bit_used)
                    begin
                        mod_word = mem_rdata & ~bit_mask;
                        mod_wr   = 1'b1;
                    end
                    else
                    begin
                        mod_status = ebpa_pkg::ST_ALREADY_FREE;
                    end
                end
                default:
                begin
                    mod_free = !bit_used;
                end
            endcase
        end
    end

    // control state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and control outputs
    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        mem_cmd    = '0;
        phys_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ebpa_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ebpa_pkg::S_FIND;
                end
            end
            ebpa_pkg::S_FIND:
            begin
                state_next = ebpa_pkg::S_READ;
            end
            ebpa_pkg::S_READ:
            begin
                mem_cmd.rd = 1'b1;
                state_next = ebpa_pkg::S_MOD;
            end
            ebpa_pkg::S_MOD:
            begin
                phys_start = 1'b1;
                state_next = ebpa_pkg::S_PHYS;
            end
            ebpa_pkg::S_PHYS:
            begin
                if (phys_done)
                begin
                    state_next = ebpa_pkg::S_DONE;
                end
            end
            ebpa_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    mem_cmd.wr = wr_reg;
                    state_next = ebpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ebpa_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            pn_reg   <= page_number;
        end
        if (state_reg == ebpa_pkg::S_FIND)
        begin
            word_idx_reg <= find_idx;
            fail_reg     <= find_fail;
            status_reg   <= find_status;
        end
        if (state_reg == ebpa_pkg::S_MOD)
        begin
            status_reg    <= mod_status;
            page_reg      <= mod_page;
            page_free_reg <= mod_free;
            new_word_reg  <= mod_word;
            new_full_reg  <= &(mod_word | tail_mask);
            wr_reg        <= mod_wr;
        end
    end

    // occupancy: word full flags and allocated total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= '0;
            total_reg <= '0;
        end
        else if (load_out && wr_reg)
        begin
            full_reg[word_idx_reg] <= new_full_reg;
            if (kind_reg == ebpa_pkg::KIND_ALLOC)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else
            begin
                total_reg <= total_reg - 1'b1;
            end
        end
    end

    // result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_out_reg <= status_reg;
            page_out_reg   <= page_reg;
            phys_out_reg   <= fail_reg ? '0 : phys_val;
            free_out_reg   <= page_free_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_out_reg;
    assign result_page   = page_out_reg;
    assign physical_page = phys_out_reg;
    assign page_free     = free_out_reg;

endmodule

// ===== rtl/ebpa_checker.sv =====
// port-level checks for the extent bitmap page allocator, bound to the top level
// depends on ebpa_pkg and extent_bitmap_page_allocator
module ebpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic [1:0]                    status,
    input logic [ebpa_pkg::PAGE_W-1:0]   result_page,
    input logic [ebpa_pkg::PHYS_W-1:0]   physical_page,
    input logic                          page_free
);

    // one request at a time: an accepted word blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted back to back");

    // refused allocation carries no page
    a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ebpa_pkg::ST_NO_FREE) |->
        (result_page == '0 && physical_page == '0 && !page_free))
        else $error("refused allocation with nonzero payload");

    // out of range page has no position
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ebpa_pkg::ST_OUT_OF_RANGE) |->
        (physical_page == '0 && !page_free))
        else $error("out of range result with position or free flag");

    // double free still reports the page as free
    a_double_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ebpa_pkg::ST_ALREADY_FREE) |-> page_free)
        else $error("double free without free flag");

    // position sits after the meta page and at most one bitmap page per extent
    a_phys_window: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ebpa_pkg::ST_OK || status == ebpa_pkg::ST_ALREADY_FREE)) |->
        (physical_page >= {1'b0, result_page} + 13'd2 &&
         physical_page <= {1'b0, result_page} + 13'd65))
        else $error("physical position outside its window");

endmodule

bind extent_bitmap_page_allocator ebpa_checker u_ebpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .status        (status),
    .result_page   (result_page),
    .physical_page (physical_page),
    .page_free     (page_free)
);

// ===== verif/tb_extent_bitmap_page_allocator.sv =====
// testbench for extent_bitmap_page_allocator: drives allocate, free and query
// words, predicts each result word from its own copy of the bitmap and counters
// depends on ebpa_pkg and the allocator rtl
module tb_extent_bitmap_page_allocator;

    localparam int PAGES_PER_EXTENT = 256;
    localparam int EXTENT_COUNT     = 16;
    localparam int PAGE_LIMIT       = 4096;
    localparam int TOTAL_PAGES      = PAGES_PER_EXTENT * EXTENT_COUNT;
    localparam int PAGE_W           = ebpa_pkg::PAGE_W;
    localparam int PHYS_W           = ebpa_pkg::PHYS_W;
    localparam int ADDR_PAGES       = ebpa_pkg::ADDR_PAGES;
    localparam int IDLE_LIMIT       = 4000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int FILL_WORDS       = 256;
    localparam int SWEEP_PAGES      = 320;
    localparam int RANDOM_WORDS     = 300;

    // the spare kind code is served like a query
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        ebpa_pkg::status_t  status;
        logic [PAGE_W-1:0]  page;
        logic [PHYS_W-1:0]  phys;
        logic               is_free;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [1:0]          kind;
    logic [PAGE_W-1:0]   page_number;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [1:0]          status;
    logic [PAGE_W-1:0]   result_page;
    logic [PHYS_W-1:0]   physical_page;
    logic                page_free;

    // shadow allocator state
    bit                  page_taken [TOTAL_PAGES];
    int unsigned         extent_fill [EXTENT_COUNT];
    int unsigned         pages_taken_total;

    alloc_result_t       awaited_results [$];
    alloc_result_t       last_answer;
    int                  error_count;
    bit                  idling_off;

    extent_bitmap_page_allocator #(
        .PAGES_PER_EXTENT (PAGES_PER_EXTENT),
        .EXTENT_COUNT     (EXTENT_COUNT),
        .PAGE_LIMIT       (PAGE_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .page_number   (page_number),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .result_page   (result_page),
        .physical_page (physical_page),
        .page_free     (page_free)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idling_off)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // file position: meta page, then per extent a bitmap page and the data pages
    function automatic logic [PHYS_W-1:0] file_position(int unsigned p);
        int unsigned ext;
        int unsigned offs;
        ext  = p / PAGES_PER_EXTENT;
        offs = p % PAGES_PER_EXTENT;
        return PHYS_W'(ext * (PAGES_PER_EXTENT + 1) + offs + 2);
    endfunction

    // apply one request to the shadow state and work out its result word
    function automatic alloc_result_t serve_request(logic [1:0] k, logic [PAGE_W-1:0] pn);
        alloc_result_t r;
        int            ext;
        int unsigned   p;
        bit            found;
        r.status  = ebpa_pkg::ST_OK;
        r.page    = '0;
        r.phys    = '0;
        r.is_free = 1'b0;

        // allocate: first extent not full, lowest free page in it
        if (k == ebpa_pkg::KIND_ALLOC)
        begin
            if (pages_taken_total >= PAGE_LIMIT)
            begin
                r.status = ebpa_pkg::ST_NO_FREE;
                return r;
            end
            ext = -1;
            for (int e = 0; e < EXTENT_COUNT; e++)
            begin
                if (ext < 0 && extent_fill[e] < PAGES_PER_EXTENT)
                    ext = e;
            end
            found = 1'b0;
            if (ext >= 0)
            begin
                for (int o = 0; o < PAGES_PER_EXTENT; o++)
                begin
                    p = ext * PAGES_PER_EXTENT + o;
                    if (!found && p < ADDR_PAGES && !page_taken[p])
                    begin
                        found = 1'b1;
                        page_taken[p] = 1'b1;
                        extent_fill[ext]++;
                        pages_taken_total++;
                        r.page = PAGE_W'(p);
                        r.phys = file_position(p);
                    end
                end
            end
            if (!found)
                r.status = ebpa_pkg::ST_NO_FREE;
            return r;
        end

        // free and query name a page
        r.page = pn;
        if (pn >= TOTAL_PAGES)
        begin
            r.status = ebpa_pkg::ST_OUT_OF_RANGE;
            return r;
        end
        r.phys = file_position(pn);
        if (k == ebpa_pkg::KIND_FREE)
        begin
            r.is_free = 1'b1;
            if (!page_taken[pn])
            begin
                r.status = ebpa_pkg::ST_ALREADY_FREE;
                return r;
            end
            page_taken[pn] = 1'b0;
            if (extent_fill[pn / PAGES_PER_EXTENT] > 0)
                extent_fill[pn / PAGES_PER_EXTENT]--;
            if (pages_taken_total > 0)
                pages_taken_total--;
            return r;
        end
        r.is_free = !page_taken[pn];
        return r;
    endfunction

    // send one request word; valid stays high when the next word follows at once
    task automatic send_word(input logic [1:0] k, input logic [PAGE_W-1:0] pn);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= k;
        page_number <= pn;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        last_answer = serve_request(k, pn);
        awaited_results.push_back(last_answer);
    endtask

    // sender pauses until every result word is back
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // corner requests from an empty allocator
    task automatic test_directed_requests();
        send_word(ebpa_pkg::KIND_ALLOC, 12'h000);
        send_word(ebpa_pkg::KIND_ALLOC, 12'hFFF);
        send_word(ebpa_pkg::KIND_ALLOC, 12'h123);
        send_word(ebpa_pkg::KIND_QUERY, 12'h000);
        send_word(ebpa_pkg::KIND_QUERY, 12'hFFF);
        send_word(ebpa_pkg::KIND_FREE, 12'h001);
        send_word(ebpa_pkg::KIND_QUERY, 12'h001);
        send_word(ebpa_pkg::KIND_ALLOC, 12'h000);
        send_word(ebpa_pkg::KIND_FREE, 12'hFFF);
        send_word(KIND_SPARE, 12'h002);
        send_word(KIND_SPARE, 12'hA5A);
        send_word(ebpa_pkg::KIND_QUERY, 12'h5A5);
        send_word(ebpa_pkg::KIND_FREE, 12'h000);
        send_word(ebpa_pkg::KIND_FREE, 12'h000);
        send_word(ebpa_pkg::KIND_ALLOC, 12'h555);
        send_word(ebpa_pkg::KIND_FREE, 12'h002);
        send_word(ebpa_pkg::KIND_QUERY, 12'h800);
        wait_results_drained();
    endtask

    // fill past the first extent, then check refills after scattered frees
    task automatic test_fill_and_refill();
        idling_off = 1'b1;
        repeat (FILL_WORDS) send_word(ebpa_pkg::KIND_ALLOC, PAGE_W'($urandom));
        idling_off = 1'b0;
        send_word(ebpa_pkg::KIND_QUERY, 12'd255);
        send_word(ebpa_pkg::KIND_FREE, 12'd200);
        send_word(ebpa_pkg::KIND_FREE, 12'd64);
        send_word(ebpa_pkg::KIND_FREE, 12'd3);
        send_word(ebpa_pkg::KIND_QUERY, 12'd64);
        repeat (4) send_word(ebpa_pkg::KIND_ALLOC, 12'h000);
        wait_results_drained();
    endtask

    // release low pages in shuffled order with an allocate every sixteen frees
    task automatic test_shuffled_release();
        int unsigned order [SWEEP_PAGES];
        int unsigned j;
        int unsigned tmp;
        for (int i = 0; i < SWEEP_PAGES; i++)
            order[i] = i;
        for (int i = SWEEP_PAGES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        idling_off = 1'b1;
        for (int i = 0; i < SWEEP_PAGES; i++)
        begin
            send_word(ebpa_pkg::KIND_FREE, PAGE_W'(order[i]));
            if (i % 16 == 15)
                send_word(ebpa_pkg::KIND_ALLOC, PAGE_W'($urandom));
        end
        idling_off = 1'b0;
        wait_results_drained();
    endtask

    // random mix, frees mostly aimed at pages known to be taken
    task automatic test_random_traffic();
        logic [PAGE_W-1:0] live_pages [$];
        int                r;
        int                idx;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // stretches without idle gaps or receiver stalls now and then
            if (n % 75 == 0)
                idling_off = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 48)
            begin
                send_word(ebpa_pkg::KIND_ALLOC, PAGE_W'($urandom));
                if (last_answer.status == ebpa_pkg::ST_OK)
                    live_pages.push_back(last_answer.page);
            end
            else if (r < 83 && live_pages.size() > 0)
            begin
                idx = $urandom_range(0, live_pages.size() - 1);
                send_word(ebpa_pkg::KIND_FREE, live_pages[idx]);
                live_pages.delete(idx);
            end
            else if (r < 90)
                send_word(ebpa_pkg::KIND_FREE, PAGE_W'($urandom));
            else if (r < 97)
                send_word(ebpa_pkg::KIND_QUERY, PAGE_W'($urandom));
            else
                send_word(KIND_SPARE, PAGE_W'($urandom));
            if (n == RANDOM_WORDS / 2)
                wait_results_drained();
        end
        idling_off = 1'b0;
        wait_results_drained();
    endtask

    // result checker and receiver stall pattern
    initial
    begin : result_checker
        alloc_result_t want;
        int            stall_left;
        bit            stall_now;
        stall_left = 0;
        stall_now  = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d page %0d",
                           status, result_page);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, status);
                        error_count++;
                    end
                    if (result_page !== want.page)
                    begin
                        $error("result_page expected %0d got %0d", want.page, result_page);
                        error_count++;
                    end
                    if (physical_page !== want.phys)
                    begin
                        $error("physical_page expected %0d got %0d", want.phys,
                               physical_page);
                        error_count++;
                    end
                    if (page_free !== want.is_free)
                    begin
                        $error("page_free expected %0d got %0d", want.is_free, page_free);
                        error_count++;
                    end
                end
            end
            // next stall run
            if (idling_off)
            begin
                stall_now  = 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
                stall_left--;
            else
            begin
                stall_now  = ($urandom_range(0, 99) < 30);
                stall_left = stall_now ? random_gap() : $urandom_range(1, 20);
            end
            rsp_stall <= stall_now;
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("extent_bitmap_page_allocator verification failed");
        $finish;
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n             <= 1'b0;
        req_valid         <= 1'b0;
        kind              <= ebpa_pkg::KIND_ALLOC;
        page_number       <= '0;
        error_count       = 0;
        idling_off        = 1'b0;
        pages_taken_total = 0;
        for (int i = 0; i < TOTAL_PAGES; i++)
            page_taken[i] = 1'b0;
        for (int e = 0; e < EXTENT_COUNT; e++)
            extent_fill[e] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_fill_and_refill();
        test_shuffled_release();
        test_random_traffic();

        if (awaited_results.size() != 0)
        begin
            $error("%0d result words never arrived", awaited_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("extent_bitmap_page_allocator verification clean");
        else
            $display("extent_bitmap_page_allocator verification failed");
        $finish;
    end

endmodule
